// File: hdl/vpy_pkg.sv
// Shared types, constants and the arctangent table for the vector pitch/yaw block.
// Used by every module under hdl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package vpy_pkg;

    // Default parameter values for the top level.
    localparam int COORD_WIDTH_DEF   = 16;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Coordinates carry 16 fraction bits and a few guard bits for CORDIC growth.
    localparam int FRAC_BITS  = 16;
    localparam int GUARD_BITS = 4;

    // Angle accumulator: 32 bits, full scale is one turn.
    localparam int ACC_W = 32;
    localparam logic [ACC_W-1:0] QUARTER_TURN     = 32'h4000_0000;
    localparam logic [ACC_W-1:0] NEG_QUARTER_TURN = 32'hC000_0000;

    // CORDIC gain in Q30, and the shift that leaves it with FRAC_BITS fraction bits.
    localparam logic [31:0] GAIN_Q30   = 32'd1768195363;
    localparam int          GAIN_SHIFT = 30 - FRAC_BITS;

    // atan(2^-i) in accumulator units, truncated.
    localparam logic [ACC_W-1:0] ATAN_TABLE [0:31] = '{
        32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
        32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051,
        32'h0000_0028, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0002, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000
    };

    // Flags that ride along with each vector through the pipeline.
    typedef struct packed {
        logic zero;      // x, y and z all zero
        logic vertical;  // x and y both zero
        logic z_neg;     // z below zero
    } flags_t;

    localparam int FLAGS_W = $bits(flags_t);

endpackage

`default_nettype wire

// File: hdl/vpy_prep.sv
// Input stage: quadrant pre-rotation, z scaling by the CORDIC gain and special-case flags.
// Depends on vpy_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpy_prep #(
    parameter int COORD_WIDTH = vpy_pkg::COORD_WIDTH_DEF,
    parameter int W           = COORD_WIDTH + vpy_pkg::FRAC_BITS + vpy_pkg::GUARD_BITS
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              en,
    input  wire                              in_valid,
    input  wire  signed [COORD_WIDTH-1:0]    vec_x,
    input  wire  signed [COORD_WIDTH-1:0]    vec_y,
    input  wire  signed [COORD_WIDTH-1:0]    vec_z,
    output logic                             out_valid,
    output logic signed [W-1:0]              out_x,
    output logic signed [W-1:0]              out_y,
    output logic [vpy_pkg::ACC_W-1:0]        out_acc,
    output logic signed [W-1:0]              out_zs,
    output vpy_pkg::flags_t                  out_flags
);

    localparam int PROD_W = COORD_WIDTH + 32;

    logic signed [W-1:0]        xs;
    logic signed [W-1:0]        ys;
    logic signed [W-1:0]        x_next;
    logic signed [W-1:0]        y_next;
    logic [vpy_pkg::ACC_W-1:0]  acc_next;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_shifted;
    vpy_pkg::flags_t            flags_next;

    logic                       valid_reg;
    logic signed [W-1:0]        x_reg;
    logic signed [W-1:0]        y_reg;
    logic [vpy_pkg::ACC_W-1:0]  acc_reg;
    logic signed [W-1:0]        zs_reg;
    vpy_pkg::flags_t            flags_reg;

    assign xs = {{(W - COORD_WIDTH){vec_x[COORD_WIDTH-1]}}, vec_x} <<< vpy_pkg::FRAC_BITS;
    assign ys = {{(W - COORD_WIDTH){vec_y[COORD_WIDTH-1]}}, vec_y} <<< vpy_pkg::FRAC_BITS;

    // The vectoring pass starts from (y, x); a negative y is first turned a quarter
    // turn so that the pass begins in the right half plane.
    always_comb begin
        x_next   = ys;
        y_next   = xs;
        acc_next = '0;
        if (ys[W-1]) begin
            if (!xs[W-1]) begin
                x_next   = xs;
                y_next   = -ys;
                acc_next = vpy_pkg::QUARTER_TURN;
            end else begin
                x_next   = -xs;
                y_next   = ys;
                acc_next = vpy_pkg::NEG_QUARTER_TURN;
            end
        end
    end

    assign prod         = vec_z * $signed({1'b0, vpy_pkg::GAIN_Q30});
    assign prod_shifted = prod >>> vpy_pkg::GAIN_SHIFT;

    always_comb begin
        flags_next.vertical = (vec_x == '0) && (vec_y == '0);
        flags_next.zero     = flags_next.vertical && (vec_z == '0);
        flags_next.z_neg    = vec_z[COORD_WIDTH-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            acc_reg   <= acc_next;
            zs_reg    <= prod_shifted[W-1:0];
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_acc   = acc_reg;
    assign out_zs    = zs_reg;
    assign out_flags = flags_reg;

endmodule

`default_nettype wire

// File: hdl/vpy_cordic_stage.sv
// One registered CORDIC vectoring iteration with a fixed shift, plus a side payload.
// Depends on vpy_pkg for the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module vpy_cordic_stage #(
    parameter int W         = 36,
    parameter int SIDE_W    = 8,
    parameter int STAGE_IDX = 0
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              en,
    input  wire                              in_valid,
    input  wire  signed [W-1:0]              in_x,
    input  wire  signed [W-1:0]              in_y,
    input  wire  [vpy_pkg::ACC_W-1:0]        in_acc,
    input  wire  [SIDE_W-1:0]                in_side,
    output logic                             out_valid,
    output logic signed [W-1:0]              out_x,
    output logic signed [W-1:0]              out_y,
    output logic [vpy_pkg::ACC_W-1:0]        out_acc,
    output logic [SIDE_W-1:0]                out_side
);

    logic signed [W-1:0]        dx;
    logic signed [W-1:0]        dy;
    logic signed [W-1:0]        x_next;
    logic signed [W-1:0]        y_next;
    logic [vpy_pkg::ACC_W-1:0]  acc_next;

    logic                       valid_reg;
    logic signed [W-1:0]        x_reg;
    logic signed [W-1:0]        y_reg;
    logic [vpy_pkg::ACC_W-1:0]  acc_reg;
    logic [SIDE_W-1:0]          side_reg;

    assign dx = in_y >>> STAGE_IDX;
    assign dy = in_x >>> STAGE_IDX;

    always_comb begin
        if (!in_y[W-1]) begin
            x_next   = in_x + dx;
            y_next   = in_y - dy;
            acc_next = in_acc + vpy_pkg::ATAN_TABLE[STAGE_IDX];
        end else begin
            x_next   = in_x - dx;
            y_next   = in_y + dy;
            acc_next = in_acc - vpy_pkg::ATAN_TABLE[STAGE_IDX];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            acc_reg  <= acc_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_acc   = acc_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// File: hdl/vpy_finish.sv
// Output stage: pitch clamp, special cases, angle rounding, output register and skid slot.
// Depends on vpy_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpy_finish #(
    parameter int ANGLE_WIDTH = vpy_pkg::ANGLE_WIDTH_DEF,
    parameter int DATA_W      = ((2 * ANGLE_WIDTH + 7) / 8) * 8
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    output logic                          en,
    input  wire                           in_valid,
    input  wire  [vpy_pkg::ACC_W-1:0]     pitch_acc,
    input  wire  [vpy_pkg::ACC_W-1:0]     yaw_acc,
    input  wire  vpy_pkg::flags_t         flags,
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    output logic [DATA_W-1:0]             m_axis_tdata,   // pitch_angle, yaw_angle
    output logic [0:0]                    m_axis_tuser    // zero_vector
);

    localparam int AW  = ANGLE_WIDTH;
    localparam int RW  = 2 * AW + 1;
    localparam logic [vpy_pkg::ACC_W-1:0] ROUND_HALF =
        vpy_pkg::ACC_W'((64'd1 << (vpy_pkg::ACC_W - AW)) >> 1);

    logic [vpy_pkg::ACC_W-1:0] pitch_pre;
    logic [vpy_pkg::ACC_W-1:0] yaw_pre;
    logic [vpy_pkg::ACC_W-1:0] pitch_sum;
    logic [vpy_pkg::ACC_W-1:0] yaw_sum;
    logic [RW-1:0]             result_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [RW-1:0]             out_data_reg;
    logic [RW-1:0]             out_data_next;
    logic                      skid_valid_reg;
    logic                      skid_valid_next;
    logic [RW-1:0]             skid_data_reg;
    logic [RW-1:0]             skid_data_next;

    always_comb begin
        if (flags.zero) begin
            pitch_pre = '0;
            yaw_pre   = '0;
        end else if (flags.vertical) begin
            pitch_pre = flags.z_neg ? vpy_pkg::NEG_QUARTER_TURN : vpy_pkg::QUARTER_TURN;
            yaw_pre   = '0;
        end else begin
            yaw_pre = yaw_acc;
            if ($signed(pitch_acc) > $signed(vpy_pkg::QUARTER_TURN)) begin
                pitch_pre = vpy_pkg::QUARTER_TURN;
            end else if ($signed(pitch_acc) < $signed(vpy_pkg::NEG_QUARTER_TURN)) begin
                pitch_pre = vpy_pkg::NEG_QUARTER_TURN;
            end else begin
                pitch_pre = pitch_acc;
            end
        end
    end

    // Round half up: add half an output step and keep the top bits.
    assign pitch_sum   = pitch_pre + ROUND_HALF;
    assign yaw_sum     = yaw_pre + ROUND_HALF;
    assign result_next = {flags.zero,
                          yaw_sum[vpy_pkg::ACC_W-1 -: AW],
                          pitch_sum[vpy_pkg::ACC_W-1 -: AW]};

    // The pipeline only halts once the skid slot is taken, so the input side keeps
    // moving while a finished result waits in the output register.
    assign en = !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (m_axis_tready) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || m_axis_tready) begin
                out_valid_next = 1'b1;
                out_data_next  = result_next;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = result_next;
            end
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'(out_data_reg[2*AW-1:0]);
    assign m_axis_tuser  = out_data_reg[2*AW];

endmodule

`default_nettype wire

// File: hdl/vector_pitch_yaw.sv
// Top level of the vector pitch/yaw block: prep stage, two CORDIC vectoring passes
// and the output stage. Depends on vpy_pkg, vpy_prep, vpy_cordic_stage and vpy_finish.
//
//   channel  | direction | tdata (low bits first)               | tuser
//   s_axis   | in        | vec_x, vec_y, vec_z                  | -
//   m_axis   | out       | pitch_angle, yaw_angle               | zero_vector
//
// One vector is taken every cycle while s_axis_tready is high. The path from the input
// transfer to m_axis_tvalid runs through the prep register, one register per CORDIC
// iteration in each of the two passes, and the output register.
// aresetn is synchronous and clears only the valid bits of every stage.
// s_axis_tready comes from a register; it drops only while the skid slot behind the
// output register holds a result, and then the prep and CORDIC stages hold their contents.
`timescale 1ns / 1ps
`default_nettype none

module vector_pitch_yaw #(
    parameter int COORD_WIDTH   = vpy_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = vpy_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = vpy_pkg::CORDIC_STAGES_DEF
) (
    input  wire                                          aclk,
    input  wire                                          aresetn,
    input  wire                                          s_axis_tvalid,
    output logic                                         s_axis_tready,
    input  wire  [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // vec_x, vec_y, vec_z
    output logic                                         m_axis_tvalid,
    input  wire                                          m_axis_tready,
    output logic [((2 * ANGLE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,  // pitch_angle, yaw_angle
    output logic [0:0]                                   m_axis_tuser   // zero_vector
);

    localparam int W       = COORD_WIDTH + vpy_pkg::FRAC_BITS + vpy_pkg::GUARD_BITS;
    localparam int N       = CORDIC_STAGES;
    localparam int FW      = vpy_pkg::FLAGS_W;
    localparam int SIDE1_W = W + FW;
    localparam int SIDE2_W = vpy_pkg::ACC_W + FW;
    localparam int M_W     = ((2 * ANGLE_WIDTH + 7) / 8) * 8;

    logic                      en;

    logic                      prep_valid;
    logic signed [W-1:0]       prep_x;
    logic signed [W-1:0]       prep_y;
    logic [vpy_pkg::ACC_W-1:0] prep_acc;
    logic signed [W-1:0]       prep_zs;
    vpy_pkg::flags_t           prep_flags;

    logic                      p1_valid [0:N];
    logic signed [W-1:0]       p1_x     [0:N];
    logic signed [W-1:0]       p1_y     [0:N];
    logic [vpy_pkg::ACC_W-1:0] p1_acc   [0:N];
    logic [SIDE1_W-1:0]        p1_side  [0:N];

    logic                      p2_valid [0:N];
    logic signed [W-1:0]       p2_x     [0:N];
    logic signed [W-1:0]       p2_y     [0:N];
    logic [vpy_pkg::ACC_W-1:0] p2_acc   [0:N];
    logic [SIDE2_W-1:0]        p2_side  [0:N];

    vpy_pkg::flags_t           fin_flags;

    assign s_axis_tready = en;

    vpy_prep #(
        .COORD_WIDTH (COORD_WIDTH),
        .W           (W)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .vec_x     (s_axis_tdata[COORD_WIDTH-1:0]),
        .vec_y     (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .vec_z     (s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .out_valid (prep_valid),
        .out_x     (prep_x),
        .out_y     (prep_y),
        .out_acc   (prep_acc),
        .out_zs    (prep_zs),
        .out_flags (prep_flags)
    );

    // First pass: vectors (y, x) for yaw and the gain-scaled horizontal magnitude.
    assign p1_valid[0] = prep_valid;
    assign p1_x[0]     = prep_x;
    assign p1_y[0]     = prep_y;
    assign p1_acc[0]   = prep_acc;
    assign p1_side[0]  = {prep_zs, prep_flags};

    // Second pass: vectors (magnitude, gain-scaled z) for pitch; yaw rides along.
    assign p2_valid[0] = p1_valid[N];
    assign p2_x[0]     = p1_x[N];
    assign p2_y[0]     = p1_side[N][SIDE1_W-1:FW];
    assign p2_acc[0]   = '0;
    assign p2_side[0]  = {p1_acc[N], p1_side[N][FW-1:0]};

    for (genvar i = 0; i < N; i++) begin : g_pass
        vpy_cordic_stage #(
            .W         (W),
            .SIDE_W    (SIDE1_W),
            .STAGE_IDX (i)
        ) u_yaw_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (p1_valid[i]),
            .in_x      (p1_x[i]),
            .in_y      (p1_y[i]),
            .in_acc    (p1_acc[i]),
            .in_side   (p1_side[i]),
            .out_valid (p1_valid[i+1]),
            .out_x     (p1_x[i+1]),
            .out_y     (p1_y[i+1]),
            .out_acc   (p1_acc[i+1]),
            .out_side  (p1_side[i+1])
        );

        vpy_cordic_stage #(
            .W         (W),
            .SIDE_W    (SIDE2_W),
            .STAGE_IDX (i)
        ) u_pitch_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (p2_valid[i]),
            .in_x      (p2_x[i]),
            .in_y      (p2_y[i]),
            .in_acc    (p2_acc[i]),
            .in_side   (p2_side[i]),
            .out_valid (p2_valid[i+1]),
            .out_x     (p2_x[i+1]),
            .out_y     (p2_y[i+1]),
            .out_acc   (p2_acc[i+1]),
            .out_side  (p2_side[i+1])
        );
    end

    assign fin_flags = vpy_pkg::flags_t'(p2_side[N][FW-1:0]);

    vpy_finish #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .DATA_W      (M_W)
    ) u_finish (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (p2_valid[N]),
        .pitch_acc     (p2_acc[N]),
        .yaw_acc       (p2_side[N][SIDE2_W-1:FW]),
        .flags         (fin_flags),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
